/* src/sha_pkg.sv */
// sha_pkg: shared types, constants and round functions for the SHA-256 hasher.
// No dependencies.
`default_nettype none

package sha_pkg;

	localparam logic [6:0] FILL_LAST_BYTE = 7'd63;
	localparam logic [6:0] FILL_PAD_END   = 7'd56;
	localparam logic [6:0] FILL_BLOCK     = 7'd64;
	localparam logic [7:0] PAD_MARK       = 8'h80;
	localparam logic [2:0] LAST_WORD_IDX  = 3'd7;
	localparam logic [5:0] LAST_ROUND     = 6'd63;

	localparam logic [31:0] K_TAB [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] IV_TAB [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD_ONE,
		ST_PAD_ZERO,
		ST_LEN,
		ST_LOAD,
		ST_RND,
		ST_ADD,
		ST_OUT
	} sha_state_t;

	typedef enum logic [1:0] {
		SRC_DATA,
		SRC_MARK,
		SRC_ZERO
	} byte_src_t;

	typedef struct packed {
		logic       wr_byte;
		byte_src_t  src;
		logic [5:0] addr;
		logic       count;
		logic       wr_len;
		logic       load;
		logic       round;
		logic [5:0] rnd;
		logic       add;
		logic       shift_out;
		logic       init;
	} sha_cmd_t;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] ssig0(input logic [31:0] x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic logic [31:0] f_ch(input logic [31:0] e, input logic [31:0] f,
			input logic [31:0] g);
		return (e & f) ^ (~e & g);
	endfunction

	function automatic logic [31:0] f_maj(input logic [31:0] a, input logic [31:0] b,
			input logic [31:0] c);
		return (a & b) ^ (a & c) ^ (b & c);
	endfunction

endpackage

`default_nettype wire

/* src/sha_dp.sv */
// sha_dp: SHA-256 datapath: block/schedule words, working variables, chaining words,
// bit counter and one compression round per cycle. Depends on sha_pkg.
`default_nettype none

module sha_dp import sha_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire sha_cmd_t    cmd,
	input  wire logic [7:0]  data_byte,
	output logic      [31:0] digest_word
);

	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [31:0] w_q [16];
	logic [63:0] bits_q;

	logic [7:0]  wr_val;
	logic [3:0]  wr_word;
	logic [4:0]  wr_lsb;
	logic [31:0] w_new;
	logic [31:0] t1;
	logic [31:0] t2;

	always_comb begin
		unique case (cmd.src)
			SRC_DATA: wr_val = data_byte;
			SRC_MARK: wr_val = PAD_MARK;
			SRC_ZERO: wr_val = 8'h00;
			default:  wr_val = 8'h00;
		endcase
	end

	// big-endian byte lanes within each word
	assign wr_word = cmd.addr[5:2];
	assign wr_lsb  = {~cmd.addr[1:0], 3'b000};

	assign w_new = w_q[0] + ssig0(w_q[1]) + w_q[9] + ssig1(w_q[14]);
	assign t1 = v_q[7] + bsig1(v_q[4]) + f_ch(v_q[4], v_q[5], v_q[6])
		+ K_TAB[cmd.rnd] + w_q[0];
	assign t2 = bsig0(v_q[0]) + f_maj(v_q[0], v_q[1], v_q[2]);

	always_ff @(posedge clk) begin
		if (cmd.wr_byte) begin
			w_q[wr_word][wr_lsb +: 8] <= wr_val;
		end else if (cmd.wr_len) begin
			w_q[14] <= bits_q[63:32];
			w_q[15] <= bits_q[31:0];
		end else if (cmd.round) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[15] <= w_new;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			v_q <= h_q;
		end else if (cmd.round) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q    <= IV_TAB;
			bits_q <= '0;
		end else begin
			if (cmd.init) begin
				h_q    <= IV_TAB;
				bits_q <= '0;
			end else begin
				if (cmd.add) begin
					for (int i = 0; i < 8; i++) begin
						h_q[i] <= h_q[i] + v_q[i];
					end
				end else if (cmd.shift_out) begin
					for (int i = 0; i < 7; i++) begin
						h_q[i] <= h_q[i + 1];
					end
					h_q[7] <= h_q[0];
				end
				if (cmd.count) begin
					bits_q <= bits_q + 64'd8;
				end
			end
		end
	end

	assign digest_word = h_q[0];

endmodule

`default_nettype wire

/* src/sha_ctrl.sv */
// sha_ctrl: SHA-256 sequencer: byte intake, padding, round count and digest beats.
// Drives sha_dp through sha_cmd_t. Depends on sha_pkg.
`default_nettype none

module sha_ctrl import sha_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       data_valid,
	output logic            data_stall,
	input  wire logic       byte_valid,
	input  wire logic       last,
	output logic            digest_valid,
	input  wire logic       digest_stall,
	output logic      [2:0] word_index,
	output logic            last_word,
	output sha_cmd_t        cmd
);

	sha_state_t state_q, state_d;
	sha_state_t ret_q, ret_d;
	logic [6:0] fill_q, fill_d;
	logic [5:0] round_q, round_d;
	logic [2:0] idx_q, idx_d;
	logic       ovf_q, ovf_d;

	logic in_acc;
	logic out_acc;
	logic zero_done;

	assign data_stall   = (state_q != ST_IDLE);
	assign digest_valid = (state_q == ST_OUT);
	assign in_acc    = data_valid && !data_stall;
	assign out_acc   = digest_valid && !digest_stall;
	assign zero_done = !ovf_q && (fill_q == FILL_PAD_END);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= ST_IDLE;
			fill_q  <= '0;
			round_q <= '0;
			idx_q   <= '0;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			fill_q  <= fill_d;
			round_q <= round_d;
			idx_q   <= idx_d;
			ovf_q   <= ovf_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		fill_d  = fill_q;
		round_d = round_q;
		idx_d   = idx_q;
		ovf_d   = ovf_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (byte_valid) begin
						if (fill_q == FILL_LAST_BYTE) begin
							fill_d  = '0;
							ret_d   = last ? ST_PAD_ONE : ST_IDLE;
							state_d = ST_LOAD;
						end else begin
							fill_d = fill_q + 7'd1;
							if (last) begin
								state_d = ST_PAD_ONE;
							end
						end
					end else if (last) begin
						state_d = ST_PAD_ONE;
					end
				end
			end
			ST_PAD_ONE: begin
				fill_d  = fill_q + 7'd1;
				ovf_d   = fill_q >= FILL_PAD_END;
				state_d = ST_PAD_ZERO;
			end
			ST_PAD_ZERO: begin
				priority if (zero_done) begin
					state_d = ST_LEN;
				end else if (fill_q == FILL_BLOCK) begin
					fill_d  = '0;
					ovf_d   = 1'b0;
					ret_d   = ST_PAD_ZERO;
					state_d = ST_LOAD;
				end else begin
					fill_d = fill_q + 7'd1;
				end
			end
			ST_LEN: begin
				ret_d   = ST_OUT;
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				round_d = '0;
				state_d = ST_RND;
			end
			ST_RND: begin
				round_d = round_q + 6'd1;
				if (round_q == LAST_ROUND) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				state_d = ret_q;
			end
			ST_OUT: begin
				if (out_acc) begin
					idx_d = idx_q + 3'd1;
					if (idx_q == LAST_WORD_IDX) begin
						fill_d  = '0;
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.src      = SRC_DATA;
		cmd.addr     = fill_q[5:0];
		cmd.rnd      = round_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.wr_byte = in_acc && byte_valid;
				cmd.count   = in_acc && byte_valid;
			end
			ST_PAD_ONE: begin
				cmd.wr_byte = 1'b1;
				cmd.src     = SRC_MARK;
			end
			ST_PAD_ZERO: begin
				cmd.wr_byte = !zero_done && (fill_q != FILL_BLOCK);
				cmd.src     = SRC_ZERO;
			end
			ST_LEN:  cmd.wr_len = 1'b1;
			ST_LOAD: cmd.load   = 1'b1;
			ST_RND:  cmd.round  = 1'b1;
			ST_ADD:  cmd.add    = 1'b1;
			ST_OUT: begin
				cmd.shift_out = out_acc;
				cmd.init      = out_acc && (idx_q == LAST_WORD_IDX);
			end
			default: begin
				cmd.src = SRC_DATA;
			end
		endcase
	end

	assign word_index = idx_q;
	assign last_word  = (idx_q == LAST_WORD_IDX);

`ifndef ASSERT_OFF
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_BLOCK)
		else $error("fill count beyond one block");

	a_round_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RND && round_q == LAST_ROUND) |=> (state_q == ST_ADD))
		else $error("round 63 not followed by chaining add");

	a_msg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && idx_q == LAST_WORD_IDX) |=> (state_q == ST_IDLE && fill_q == '0))
		else $error("no clean restart after final digest beat");

	a_ovf_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PAD_ZERO && ovf_q) |-> (fill_q > FILL_PAD_END))
		else $error("overflow padding with fill at or below length slot");
`endif

endmodule

`default_nettype wire

/* src/sha256_stream_hasher.sv */
// sha256_stream_hasher: top level of the SHA-256 byte-stream hasher.
// Instantiates sha_ctrl and sha_dp. Depends on sha_pkg.
`default_nettype none

// One message byte is taken per beat while the hasher is idle; an item with
// byte_valid low carries no byte, and last closes the message. Each full 64-byte
// block stalls the input through its compression (load, 64 rounds, chaining add),
// so no byte of a long message is taken while a block is being compressed.
// After a last beat the input stays stalled through padding: the 0x80 byte, the
// zero bytes up to the length slot and a step to close the zero run (and one more
// step at the block boundary when padding spills into a second block), the
// length, then one or two compressions. The eight digest words then leave as
// eight beats, word 0 first, and the hasher returns to the initial chaining
// values.
module sha256_stream_hasher import sha_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        data_valid,
	output logic             data_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        byte_valid,
	input  wire logic        last,
	output logic             digest_valid,
	input  wire logic        digest_stall,
	output logic      [31:0] digest_word,
	output logic      [2:0]  word_index,
	output logic             last_word
);

	sha_cmd_t cmd;

	sha_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.data_valid   (data_valid),
		.data_stall   (data_stall),
		.byte_valid   (byte_valid),
		.last         (last),
		.digest_valid (digest_valid),
		.digest_stall (digest_stall),
		.word_index   (word_index),
		.last_word    (last_word),
		.cmd          (cmd)
	);

	sha_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.data_byte   (data_byte),
		.digest_word (digest_word)
	);

endmodule

`default_nettype wire
